/* hdl/sbtq_pkg.sv */
// Shared types and codes for the sphere body table query block.
// No dependencies; every other file in hdl takes its names from here.
`default_nettype none

package sbtq_pkg;

   localparam int MAX_BODIES_DEF = 32;
   localparam int IDX_W          = 5;

   // request codes
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_BAD_SLOT = 2'd2;
   localparam logic [1:0] STAT_NO_MATCH = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [IDX_W-1:0]   slot_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [22:0]        sphere_radius;
   } sbtq_req_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] result_index;
      logic             last;
   } sbtq_rsp_item_type;

   // one slot record as it travels round the ring
   typedef struct packed {
      logic               active;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [22:0]        radius;
   } sbtq_body_type;

   // slot presented to the distance pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } sbtq_probe_type;

   // verdict returned by the distance pipeline
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] index;
   } sbtq_hit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } sbtq_state_type;

endpackage

`default_nettype wire

/* hdl/sbtq_cell.sv */
// One slot of the body ring: holds a record and passes it to its neighbour.
// Depends on sbtq_pkg for the record type.
`default_nettype none

module sbtq_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift,
   input  wire sbtq_pkg::sbtq_body_type body_in,
   output      sbtq_pkg::sbtq_body_type body_out
);

   logic               active_ff;
   logic signed [23:0] x_ff;
   logic signed [23:0] y_ff;
   logic signed [23:0] z_ff;
   logic [22:0]        radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (shift) begin
         active_ff <= body_in.active;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         x_ff      <= body_in.x;
         y_ff      <= body_in.y;
         z_ff      <= body_in.z;
         radius_ff <= body_in.radius;
      end
   end

   assign body_out.active = active_ff;
   assign body_out.x      = x_ff;
   assign body_out.y      = y_ff;
   assign body_out.z      = z_ff;
   assign body_out.radius = radius_ff;

endmodule

`default_nettype wire

/* hdl/sbtq_dist.sv */
// Three-stage sphere overlap test: abs differences, squares, sum and compare.
// Depends on sbtq_pkg for the body, request, probe and verdict types.
`default_nettype none

module sbtq_dist (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sbtq_pkg::sbtq_probe_type    probe,
   input  wire sbtq_pkg::sbtq_req_item_type query,
   input  wire sbtq_pkg::sbtq_body_type     body,
   output      sbtq_pkg::sbtq_hit_type      verdict
);

   function automatic logic [23:0] abs_diff(logic signed [23:0] a, logic signed [23:0] b);
      logic signed [24:0] d;
      d = {a[23], a} - {b[23], b};
      abs_diff = d[24] ? 24'(-d) : 24'(d);
   endfunction

   logic                        a_valid_ff;
   logic [sbtq_pkg::IDX_W-1:0]  a_idx_ff;
   logic [23:0]                 a_dx_ff, a_dy_ff, a_dz_ff, a_rs_ff;

   logic                        b_valid_ff;
   logic [sbtq_pkg::IDX_W-1:0]  b_idx_ff;
   logic [47:0]                 b_sx_ff, b_sy_ff, b_sz_ff, b_rsq_ff;

   logic                        c_valid_ff;
   logic                        c_hit_ff;
   logic [sbtq_pkg::IDX_W-1:0]  c_idx_ff;

   logic [49:0]                 dist_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= probe.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff <= probe.index;
      a_dx_ff  <= abs_diff(body.x, query.pos_x);
      a_dy_ff  <= abs_diff(body.y, query.pos_y);
      a_dz_ff  <= abs_diff(body.z, query.pos_z);
      a_rs_ff  <= 24'(body.radius) + 24'(query.sphere_radius);

      b_idx_ff <= a_idx_ff;
      b_sx_ff  <= a_dx_ff * a_dx_ff;
      b_sy_ff  <= a_dy_ff * a_dy_ff;
      b_sz_ff  <= a_dz_ff * a_dz_ff;
      b_rsq_ff <= a_rs_ff * a_rs_ff;

      c_idx_ff <= b_idx_ff;
      c_hit_ff <= (dist_sq <= 50'(b_rsq_ff));
   end

   assign dist_sq = 50'(b_sx_ff) + 50'(b_sy_ff) + 50'(b_sz_ff);

   assign verdict.valid = c_valid_ff;
   assign verdict.hit   = c_hit_ff;
   assign verdict.index = c_idx_ff;

endmodule

`default_nettype wire

/* hdl/sbtq_ctrl.sv */
// Sequencer for the body ring: steps the ring, edits the passing record,
// feeds the distance pipeline and forms the results. Depends on sbtq_pkg.
`default_nettype none

module sbtq_ctrl #(
   parameter int SLOTS = sbtq_pkg::MAX_BODIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire sbtq_pkg::sbtq_req_item_type req_item,
   input  wire sbtq_pkg::sbtq_body_type     head_body,
   input  wire sbtq_pkg::sbtq_hit_type      dist_hit,
   output      logic                        busy,
   output      logic                        shift,
   output      sbtq_pkg::sbtq_body_type     wrap_body,
   output      sbtq_pkg::sbtq_probe_type    probe,
   output      sbtq_pkg::sbtq_req_item_type query,
   output      logic                        rsp_strobe,
   output      sbtq_pkg::sbtq_rsp_item_type rsp_item
);

   localparam int         CNT_W      = $clog2(SLOTS);
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   sbtq_pkg::sbtq_state_type    state_ff, state_in;
   sbtq_pkg::sbtq_req_item_type req_ff;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [1:0]                  drain_ff, drain_in;
   logic                        found_ff, found_in;
   logic                        slot_ok_ff, slot_ok_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [sbtq_pkg::IDX_W-1:0]  add_idx_ff, add_idx_in;
   logic [sbtq_pkg::IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   logic                        accept;
   logic                        running;
   logic                        slot_sel;
   logic                        add_take;

   assign accept   = start && (state_ff == sbtq_pkg::ST_IDLE);
   assign running  = (state_ff == sbtq_pkg::ST_RUN);
   assign slot_sel = running && (sbtq_pkg::IDX_W'(cnt_ff) == req_ff.slot_index)
                     && head_body.active;
   assign add_take = running && (req_ff.req_type == sbtq_pkg::OP_ADD)
                     && !head_body.active && !found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbtq_pkg::ST_IDLE: begin
            if (start && (req_item.req_type inside {sbtq_pkg::OP_ADD, sbtq_pkg::OP_UPDATE,
                  sbtq_pkg::OP_REMOVE, sbtq_pkg::OP_QUERY, sbtq_pkg::OP_CLEAR})) begin
               state_in = sbtq_pkg::ST_RUN;
            end
         end
         sbtq_pkg::ST_RUN: begin
            if (cnt_ff == CNT_W'(SLOTS - 1)) begin
               state_in = sbtq_pkg::ST_DRAIN;
            end
         end
         sbtq_pkg::ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               state_in = sbtq_pkg::ST_DONE;
            end
         end
         sbtq_pkg::ST_DONE: begin
            state_in = sbtq_pkg::ST_IDLE;
         end
         default: begin
            state_in = sbtq_pkg::ST_IDLE;
         end
      endcase
   end

   // working registers
   always_comb begin
      cnt_in        = cnt_ff;
      drain_in      = drain_ff;
      found_in      = found_ff;
      slot_ok_in    = slot_ok_ff;
      pend_valid_in = pend_valid_ff;
      add_idx_in    = add_idx_ff;
      pend_idx_in   = pend_idx_ff;
      if (accept) begin
         cnt_in        = '0;
         drain_in      = '0;
         found_in      = 1'b0;
         slot_ok_in    = 1'b0;
         pend_valid_in = 1'b0;
      end
      if (running) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (state_ff == sbtq_pkg::ST_DRAIN) begin
         drain_in = drain_ff + 1'b1;
      end
      if (add_take) begin
         found_in   = 1'b1;
         add_idx_in = sbtq_pkg::IDX_W'(cnt_ff);
      end
      if (slot_sel) begin
         slot_ok_in = 1'b1;
      end
      // keep the newest match back until we know whether it is the last
      if (dist_hit.valid && dist_hit.hit) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = dist_hit.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sbtq_pkg::ST_IDLE;
         cnt_ff        <= '0;
         drain_ff      <= '0;
         found_ff      <= 1'b0;
         slot_ok_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         drain_ff      <= drain_in;
         found_ff      <= found_in;
         slot_ok_ff    <= slot_ok_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      add_idx_ff  <= add_idx_in;
      pend_idx_ff <= pend_idx_in;
   end

   // outputs
   always_comb begin
      busy        = (state_ff != sbtq_pkg::ST_IDLE);
      shift       = running;
      query       = req_ff;
      probe.valid = running && (req_ff.req_type == sbtq_pkg::OP_QUERY) && head_body.active;
      probe.index = sbtq_pkg::IDX_W'(cnt_ff);

      // edit the record leaving the head as it wraps to the tail
      wrap_body = head_body;
      if (add_take) begin
         wrap_body.active = 1'b1;
         wrap_body.x      = req_ff.pos_x;
         wrap_body.y      = req_ff.pos_y;
         wrap_body.z      = req_ff.pos_z;
         wrap_body.radius = req_ff.sphere_radius;
      end
      if (slot_sel && (req_ff.req_type == sbtq_pkg::OP_UPDATE)) begin
         wrap_body.x = req_ff.pos_x;
         wrap_body.y = req_ff.pos_y;
         wrap_body.z = req_ff.pos_z;
      end
      if (slot_sel && (req_ff.req_type == sbtq_pkg::OP_REMOVE)) begin
         wrap_body.active = 1'b0;
      end
      if (running && (req_ff.req_type == sbtq_pkg::OP_CLEAR)) begin
         wrap_body.active = 1'b0;
      end

      rsp_strobe            = 1'b0;
      rsp_item.status       = sbtq_pkg::STAT_OK;
      rsp_item.result_index = '0;
      rsp_item.last         = 1'b0;
      if (dist_hit.valid && dist_hit.hit && pend_valid_ff) begin
         rsp_strobe            = 1'b1;
         rsp_item.result_index = pend_idx_ff;
      end
      if (state_ff == sbtq_pkg::ST_DONE) begin
         rsp_strobe    = 1'b1;
         rsp_item.last = 1'b1;
         case (req_ff.req_type)
            sbtq_pkg::OP_ADD: begin
               rsp_item.status       = found_ff ? sbtq_pkg::STAT_OK : sbtq_pkg::STAT_FULL;
               rsp_item.result_index = found_ff ? add_idx_ff : '0;
            end
            sbtq_pkg::OP_UPDATE, sbtq_pkg::OP_REMOVE: begin
               rsp_item.status       = slot_ok_ff ? sbtq_pkg::STAT_OK
                                                  : sbtq_pkg::STAT_BAD_SLOT;
               rsp_item.result_index = req_ff.slot_index;
            end
            sbtq_pkg::OP_QUERY: begin
               rsp_item.status       = pend_valid_ff ? sbtq_pkg::STAT_OK
                                                     : sbtq_pkg::STAT_NO_MATCH;
               rsp_item.result_index = pend_valid_ff ? pend_idx_ff : '0;
            end
            default: begin
               rsp_item.status       = sbtq_pkg::STAT_OK;
               rsp_item.result_index = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/sphere_body_table_query.sv */
// Every request (add, update, remove, query, clear) holds busy high for one
// full revolution of the body ring, a drain of the distance pipeline and the
// closing result. The body records sit in a ring of SLOTS cells, SLOTS being
// MAX_BODIES capped at 32, that steps once per cycle while a request runs.
// A query delivers its matches in slot order, one per cycle at most, during
// the revolution and drain; the final transfer (last high) always comes in the
// last busy cycle. Results cannot be held off, so take each one on the cycle
// its strobe is high. Request codes 5 to 7 are taken and dropped with no
// result and no busy time.
`default_nettype none

module sphere_body_table_query #(
   parameter int MAX_BODIES = sbtq_pkg::MAX_BODIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire sbtq_pkg::sbtq_req_item_type req_item,
   output      logic                        busy,
   output      logic                        rsp_strobe,
   output      sbtq_pkg::sbtq_rsp_item_type rsp_item
);

   localparam int SLOTS = (MAX_BODIES < 32) ? MAX_BODIES : 32;

   sbtq_pkg::sbtq_body_type     chain_body [SLOTS];
   sbtq_pkg::sbtq_body_type     wrap_body;
   sbtq_pkg::sbtq_probe_type    probe;
   sbtq_pkg::sbtq_hit_type      dist_hit;
   sbtq_pkg::sbtq_req_item_type query;
   logic                        shift;

   genvar i;
   generate
      for (i = 0; i < SLOTS; i++) begin : g_cell
         if (i == SLOTS - 1) begin : g_tail
            sbtq_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (shift),
               .body_in  (wrap_body),
               .body_out (chain_body[i])
            );
         end else begin : g_body
            sbtq_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift    (shift),
               .body_in  (chain_body[i+1]),
               .body_out (chain_body[i])
            );
         end
      end
   endgenerate

   sbtq_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .probe   (probe),
      .query   (query),
      .body    (chain_body[0]),
      .verdict (dist_hit)
   );

   sbtq_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .head_body  (chain_body[0]),
      .dist_hit   (dist_hit),
      .busy       (busy),
      .shift      (shift),
      .wrap_body  (wrap_body),
      .probe      (probe),
      .query      (query),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

/* hdl/sbtq_checker.sv */
// Port-level checks for sphere_body_table_query, bound to the top level.
// Depends on sbtq_pkg for the item types and codes.
`default_nettype none

module sbtq_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire sbtq_pkg::sbtq_req_item_type req_item,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire sbtq_pkg::sbtq_rsp_item_type rsp_item
);

   // a valid request occupies the block from the next cycle
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type <= sbtq_pkg::OP_CLEAR)) |=> busy)
      else $error("valid request did not raise busy");

   // unknown codes are dropped without result or busy time
   a_unknown_dropped: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type > sbtq_pkg::OP_CLEAR))
      |=> (!busy && !rsp_strobe))
      else $error("unknown request code was not dropped");

   // results only appear while a request is in hand
   a_strobe_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // the block frees up right after the closing result
   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |=> !busy)
      else $error("busy held after final result");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_strobe && rsp_item.last))
      else $error("busy dropped without a final result");

endmodule

bind sphere_body_table_query sbtq_checker u_sbtq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .req_item   (req_item),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
